/* rtl/core/frgf_pkg.sv */
package frgf_pkg;

	// default coordinate width in bits
	localparam int COORD_BITS_DEF = 8;

	// configuration port geometry
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 24;

	// font rom layout
	localparam int          ADDR_BITS         = 24;
	localparam logic [23:0] ASCII_BASE_RESET  = 24'h03B7C0;
	localparam logic [23:0] HANZI_BASE_RESET  = 24'h000000;
	localparam int          HANZI_ROW_LEN     = 94;
	localparam logic [6:0]  HANZI_ROW_A9      = 7'd3;
	localparam logic [6:0]  HANZI_ROW_B0      = 7'd9;

	// character code limits
	localparam logic [7:0] GB_LEAD_MIN   = 8'hA1;
	localparam logic [7:0] GB_SYM_LAST   = 8'hA3;
	localparam logic [7:0] GB_SYM_EXTRA  = 8'hA9;
	localparam logic [7:0] GB_HANZI_MIN  = 8'hB0;
	localparam logic [7:0] GB_HANZI_MAX  = 8'hF7;
	localparam logic [7:0] GB_TRAIL_MIN  = 8'hA1;
	localparam logic [7:0] GB_TRAIL_MAX  = 8'hFE;
	localparam logic [7:0] ASCII_MIN     = 8'h20;
	localparam logic [7:0] ASCII_MAX     = 8'h7E;

	// spi bytes
	localparam logic [7:0] SPI_FAST_READ = 8'h0B;
	localparam logic [7:0] SPI_DUMMY     = 8'h8D;
	localparam logic [7:0] SPI_CLOCK     = 8'h00;

	// command queue depth
	localparam int CMD_FIFO_DEPTH = 2;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_START_X,
		REG_START_Y,
		REG_ASCII_BASE,
		REG_HANZI_BASE
	} cfg_reg_t;

	// result kinds on the output channel
	typedef enum logic [1:0] {
		KIND_SPI    = 2'd0,
		KIND_COLUMN = 2'd1,
		KIND_STATUS = 2'd2
	} res_kind_t;

	// status codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_INVALID    = 2'd1,
		ST_UNEXPECTED = 2'd2
	} status_t;

	// command kinds passed from front to back
	typedef enum logic [1:0] {
		CMD_STATUS,
		CMD_FETCH,
		CMD_COLUMN
	} cmd_kind_t;

	// one queued command; column x travels beside it
	typedef struct packed {
		cmd_kind_t             kind;
		status_t               status;
		logic                  last;
		logic [ADDR_BITS-1:0]  addr;
		logic [7:0]            y;
		logic [7:0]            bits;
	} cmd_t;

	// mirror a byte so that bit 0 lands on bit 7
	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7-i] = v[i];
		end
		return r;
	endfunction

endpackage

/* rtl/core/frgf_if.sv */
// text and rom reply transactions into the fetcher
interface frgf_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;
	logic       end_of_text;

	modport source (output valid, output func, output data_byte, output end_of_text,
		input ready);
	modport sink (input valid, input func, input data_byte, input end_of_text,
		output ready);
endinterface

// result transactions out of the fetcher
interface frgf_out_if #(
	parameter int COORD_BITS = frgf_pkg::COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            kind;
	logic [7:0]            spi_byte;
	logic                  chip_select;
	logic [COORD_BITS-1:0] column_x;
	logic [7:0]            column_y;
	logic [7:0]            column_bits;
	logic [1:0]            status;
	logic                  glyph_done;

	modport source (output valid, output kind, output spi_byte, output chip_select,
		output column_x, output column_y, output column_bits, output status,
		output glyph_done, input ready);
	modport sink (input valid, input kind, input spi_byte, input chip_select,
		input column_x, input column_y, input column_bits, input status,
		input glyph_done, output ready);
endinterface

/* rtl/core/frgf_front.sv */
module frgf_front #(
	parameter int COORD_BITS = frgf_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	frgf_in_if.sink                             in,
	input  logic                                cfg_we,
	input  logic [frgf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [frgf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                cmd_full,
	output logic                                cmd_push,
	output frgf_pkg::cmd_t                      cmd,
	output logic [COORD_BITS-1:0]               cmd_x
);

	// configuration registers
	logic [7:0]                      start_x_q;
	logic [7:0]                      start_y_q;
	logic [frgf_pkg::ADDR_BITS-1:0]  ascii_base_q;
	logic [frgf_pkg::ADDR_BITS-1:0]  hanzi_base_q;

	// decode state
	logic [7:0]            lead_byte_q, lead_byte_n;
	logic                  lead_pending_q, lead_pending_n;
	logic [COORD_BITS-1:0] cursor_q, cursor_n;
	logic                  wide_q, wide_n;
	logic [4:0]            reply_idx_q, reply_idx_n;
	logic                  fetching_q, fetching_n;
	logic                  eot_pending_q, eot_pending_n;

	logic                  accept;
	logic [7:0]            b;
	logic                  eot;
	logic [6:0]            row;
	logic                  row_ok;
	logic                  trail_ok;
	logic [12:0]           hanzi_idx;
	logic [frgf_pkg::ADDR_BITS-1:0] hanzi_addr;
	logic [frgf_pkg::ADDR_BITS-1:0] ascii_addr;
	logic [3:0]            col_off;
	logic                  col_lower;
	logic                  col_last;
	logic [COORD_BITS-1:0] step_w;
	logic [COORD_BITS-1:0] narrow_w;
	logic [COORD_BITS-1:0] wide_w;
	logic [COORD_BITS-1:0] home_x;

	assign in.ready = !cmd_full;
	assign accept   = in.valid && in.ready;
	assign b        = in.data_byte;
	assign eot      = in.end_of_text;
	assign narrow_w = COORD_BITS'(8);
	assign wide_w   = COORD_BITS'(16);
	assign home_x   = COORD_BITS'(start_x_q);

	// gb2312 row number, symbol rows first then hanzi rows
	always_comb begin
		row    = '0;
		row_ok = 1'b1;
		priority if (lead_byte_q >= frgf_pkg::GB_LEAD_MIN &&
				lead_byte_q <= frgf_pkg::GB_SYM_LAST) begin
			row = 7'(lead_byte_q - frgf_pkg::GB_LEAD_MIN);
		end else if (lead_byte_q == frgf_pkg::GB_SYM_EXTRA) begin
			row = frgf_pkg::HANZI_ROW_A9;
		end else if (lead_byte_q >= frgf_pkg::GB_HANZI_MIN &&
				lead_byte_q <= frgf_pkg::GB_HANZI_MAX) begin
			row = 7'(lead_byte_q - frgf_pkg::GB_HANZI_MIN) + frgf_pkg::HANZI_ROW_B0;
		end else begin
			row_ok = 1'b0;
		end
	end

	// glyph addresses
	assign trail_ok   = b >= frgf_pkg::GB_TRAIL_MIN && b <= frgf_pkg::GB_TRAIL_MAX;
	assign hanzi_idx  = 13'(row) * 13'(frgf_pkg::HANZI_ROW_LEN)
		+ 13'(b - frgf_pkg::GB_TRAIL_MIN);
	assign hanzi_addr = hanzi_base_q + frgf_pkg::ADDR_BITS'({hanzi_idx, 5'b0});
	assign ascii_addr = ascii_base_q
		+ frgf_pkg::ADDR_BITS'({7'(b - frgf_pkg::ASCII_MIN), 4'b0});

	// column position inside the current glyph
	assign col_off   = wide_q ? reply_idx_q[3:0] : {1'b0, reply_idx_q[2:0]};
	assign col_lower = wide_q ? reply_idx_q[4] : reply_idx_q[3];
	assign col_last  = wide_q ? (reply_idx_q == 5'd31) : (reply_idx_q == 5'd15);
	assign step_w    = wide_q ? wide_w : narrow_w;

	// classify the transaction and build the command
	always_comb begin
		lead_byte_n    = lead_byte_q;
		lead_pending_n = lead_pending_q;
		cursor_n       = cursor_q;
		wide_n         = wide_q;
		reply_idx_n    = reply_idx_q;
		fetching_n     = fetching_q;
		eot_pending_n  = eot_pending_q;
		cmd_push       = 1'b0;
		cmd            = '0;
		cmd.kind       = frgf_pkg::CMD_STATUS;
		cmd.status     = frgf_pkg::ST_OK;
		cmd_x          = cursor_q + COORD_BITS'(col_off);
		if (accept) begin
			if (in.func) begin
				cmd_push = 1'b1;
				if (!fetching_q) begin
					cmd.status = frgf_pkg::ST_UNEXPECTED;
				end else begin
					cmd.kind = frgf_pkg::CMD_COLUMN;
					cmd.last = col_last;
					cmd.y    = col_lower ? start_y_q + 8'd8 : start_y_q;
					cmd.bits = frgf_pkg::reverse8(b);
					if (col_last) begin
						fetching_n    = 1'b0;
						reply_idx_n   = '0;
						eot_pending_n = 1'b0;
						cursor_n      = eot_pending_q ? home_x : cursor_q + step_w;
					end else begin
						reply_idx_n = reply_idx_q + 5'd1;
					end
				end
			end else if (fetching_q) begin
				cmd_push   = 1'b1;
				cmd.status = frgf_pkg::ST_UNEXPECTED;
			end else if (lead_pending_q) begin
				lead_pending_n = 1'b0;
				cmd_push       = 1'b1;
				if (!trail_ok || !row_ok) begin
					cmd.status = frgf_pkg::ST_INVALID;
					cursor_n   = eot ? home_x : cursor_q + wide_w;
				end else begin
					cmd.kind      = frgf_pkg::CMD_FETCH;
					cmd.addr      = hanzi_addr;
					fetching_n    = 1'b1;
					wide_n        = 1'b1;
					reply_idx_n   = '0;
					eot_pending_n = eot;
				end
			end else if (b > frgf_pkg::GB_LEAD_MIN - 8'd1) begin
				if (eot) begin
					cmd_push   = 1'b1;
					cmd.status = frgf_pkg::ST_INVALID;
					cursor_n   = home_x;
				end else begin
					lead_byte_n    = b;
					lead_pending_n = 1'b1;
				end
			end else if (b < frgf_pkg::ASCII_MIN || b > frgf_pkg::ASCII_MAX) begin
				cmd_push   = 1'b1;
				cmd.status = frgf_pkg::ST_INVALID;
				cursor_n   = eot ? home_x : cursor_q + narrow_w;
			end else begin
				cmd_push      = 1'b1;
				cmd.kind      = frgf_pkg::CMD_FETCH;
				cmd.addr      = ascii_addr;
				fetching_n    = 1'b1;
				wide_n        = 1'b0;
				reply_idx_n   = '0;
				eot_pending_n = eot;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q    <= '0;
			start_y_q    <= '0;
			ascii_base_q <= frgf_pkg::ASCII_BASE_RESET;
			hanzi_base_q <= frgf_pkg::HANZI_BASE_RESET;
		end else if (cfg_we) begin
			unique case (frgf_pkg::cfg_reg_t'(cfg_index))
				frgf_pkg::REG_START_X:    start_x_q    <= cfg_data[7:0];
				frgf_pkg::REG_START_Y:    start_y_q    <= cfg_data[7:0];
				frgf_pkg::REG_ASCII_BASE: ascii_base_q <= cfg_data;
				frgf_pkg::REG_HANZI_BASE: hanzi_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode state; a start_x write also homes the cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_byte_q    <= '0;
			lead_pending_q <= 1'b0;
			cursor_q       <= '0;
			wide_q         <= 1'b0;
			reply_idx_q    <= '0;
			fetching_q     <= 1'b0;
			eot_pending_q  <= 1'b0;
		end else begin
			lead_byte_q    <= lead_byte_n;
			lead_pending_q <= lead_pending_n;
			wide_q         <= wide_n;
			reply_idx_q    <= reply_idx_n;
			fetching_q     <= fetching_n;
			eot_pending_q  <= eot_pending_n;
			if (cfg_we && cfg_index == frgf_pkg::REG_START_X) begin
				cursor_q <= COORD_BITS'(cfg_data[7:0]);
			end else begin
				cursor_q <= cursor_n;
			end
		end
	end

endmodule

/* rtl/core/frgf_cmd_fifo.sv */
module frgf_cmd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = frgf_pkg::CMD_FIFO_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_BITS = $clog2(DEPTH);
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = count_q == CNT_BITS'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// storage slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/frgf_back.sv */
module frgf_back #(
	parameter int COORD_BITS = frgf_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_empty,
	input  frgf_pkg::cmd_t        cmd,
	input  logic [COORD_BITS-1:0] cmd_x,
	output logic                  cmd_pop,
	frgf_out_if.source            out
);

	logic [2:0]            step_q;
	logic                  out_valid_q;
	logic [1:0]            kind_q;
	logic [7:0]            spi_q;
	logic                  cs_q;
	logic [COORD_BITS-1:0] x_q;
	logic [7:0]            y_q;
	logic [7:0]            bits_q;
	logic [1:0]            status_q;
	logic                  done_q;

	logic                  load;
	logic                  final_step;
	frgf_pkg::res_kind_t   r_kind;
	logic [7:0]            r_spi;
	logic                  r_cs;
	logic [COORD_BITS-1:0] r_x;
	logic [7:0]            r_y;
	logic [7:0]            r_bits;
	frgf_pkg::status_t     r_status;
	logic                  r_done;

	assign load    = !cmd_empty && (!out_valid_q || out.ready);
	assign cmd_pop = load && final_step;

	// expand the head command into its current result
	always_comb begin
		r_kind     = frgf_pkg::KIND_SPI;
		r_spi      = frgf_pkg::SPI_CLOCK;
		r_cs       = 1'b1;
		r_x        = '0;
		r_y        = '0;
		r_bits     = '0;
		r_status   = frgf_pkg::ST_OK;
		r_done     = 1'b0;
		final_step = 1'b1;
		unique case (cmd.kind)
			frgf_pkg::CMD_FETCH: begin
				final_step = step_q == 3'd5;
				unique case (step_q)
					3'd0:    r_spi = frgf_pkg::SPI_FAST_READ;
					3'd1:    r_spi = cmd.addr[23:16];
					3'd2:    r_spi = cmd.addr[15:8];
					3'd3:    r_spi = cmd.addr[7:0];
					3'd4:    r_spi = frgf_pkg::SPI_DUMMY;
					default: r_spi = frgf_pkg::SPI_CLOCK;
				endcase
			end
			frgf_pkg::CMD_COLUMN: begin
				final_step = cmd.last || step_q != 3'd0;
				if (step_q == 3'd0) begin
					r_kind = frgf_pkg::KIND_COLUMN;
					r_spi  = '0;
					r_cs   = !cmd.last;
					r_x    = cmd_x;
					r_y    = cmd.y;
					r_bits = cmd.bits;
					r_done = cmd.last;
				end
			end
			default: begin
				r_kind   = frgf_pkg::KIND_STATUS;
				r_spi    = '0;
				r_cs     = 1'b0;
				r_status = cmd.status;
				r_done   = 1'b1;
			end
		endcase
	end

	// step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= final_step ? 3'd0 : step_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= r_kind;
			spi_q    <= r_spi;
			cs_q     <= r_cs;
			x_q      <= r_x;
			y_q      <= r_y;
			bits_q   <= r_bits;
			status_q <= r_status;
			done_q   <= r_done;
		end
	end

	assign out.valid       = out_valid_q;
	assign out.kind        = kind_q;
	assign out.spi_byte    = spi_q;
	assign out.chip_select = cs_q;
	assign out.column_x    = x_q;
	assign out.column_y    = y_q;
	assign out.column_bits = bits_q;
	assign out.status      = status_q;
	assign out.glyph_done  = done_q;

endmodule

/* rtl/core/font_rom_glyph_fetcher.sv */
// path: the first result of an input transaction passes through the command queue and
// the back end's output register before it is valid on out
// throughput: one result per cycle while out is ready; a text byte that starts a fetch
// gives six results, a reply during a fetch two (one on the last column), all loaded
// by the back end into the output register
// reset: arst_n clears queue, decode state and output valid; config regs take defaults
module font_rom_glyph_fetcher #(
	parameter int COORD_BITS = frgf_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	frgf_in_if.sink                             in,
	frgf_out_if.source                          out,
	input  logic                                cfg_we,
	input  logic [frgf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [frgf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int ENTRY_BITS = $bits(frgf_pkg::cmd_t) + COORD_BITS;

	logic                  cmd_push;
	logic                  cmd_pop;
	logic                  cmd_full;
	logic                  cmd_empty;
	frgf_pkg::cmd_t        cmd_wr;
	frgf_pkg::cmd_t        cmd_rd;
	logic [COORD_BITS-1:0] x_wr;
	logic [COORD_BITS-1:0] x_rd;

	// decode and classify
	frgf_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_full  (cmd_full),
		.cmd_push  (cmd_push),
		.cmd       (cmd_wr),
		.cmd_x     (x_wr)
	);

	// command queue between the two sides
	frgf_cmd_fifo #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (frgf_pkg::CMD_FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  ({cmd_wr, x_wr}),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  ({cmd_rd, x_rd}),
		.empty  (cmd_empty)
	);

	// result sequencing
	frgf_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_rd),
		.cmd_x     (x_rd),
		.cmd_pop   (cmd_pop),
		.out       (out)
	);

endmodule

/* rtl/core/frgf_checker.sv */
module frgf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_spi_byte,
	input logic       out_chip_select,
	input logic       out_glyph_done
);

	// status transactions release the rom and close the glyph
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == frgf_pkg::KIND_STATUS |-> out_glyph_done && !out_chip_select)
		else $error("status transaction without glyph_done or with chip_select");

	// spi transactions keep the rom selected and never close a glyph
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == frgf_pkg::KIND_SPI |-> out_chip_select && !out_glyph_done)
		else $error("spi transaction with bad chip_select or glyph_done");

	// a column releases the rom exactly when it closes the glyph
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == frgf_pkg::KIND_COLUMN |-> out_chip_select != out_glyph_done)
		else $error("column chip_select disagrees with glyph_done");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_spi_byte))
		else $error("stalled result changed");

endmodule

bind font_rom_glyph_fetcher frgf_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out.valid),
	.out_ready       (out.ready),
	.out_kind        (out.kind),
	.out_spi_byte    (out.spi_byte),
	.out_chip_select (out.chip_select),
	.out_glyph_done  (out.glyph_done)
);

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	// item kinds on the input channel
	localparam logic FUNC_TEXT  = 1'b0;
	localparam logic FUNC_REPLY = 1'b1;

	localparam int QUIET_LIMIT  = 2000;
	localparam int NO_INTRUSION = -1;
	localparam int SETTLE_GAP   = 8;
	localparam int MAX_REPORTS  = 50;

	typedef struct {
		logic       func;
		logic [7:0] data_byte;
		logic       end_of_text;
		logic       hold;
	} fetch_in_t;

	typedef struct {
		frgf_pkg::res_kind_t                 kind;
		logic [7:0]                          spi_byte;
		logic                                chip_select;
		logic [frgf_pkg::COORD_BITS_DEF-1:0] column_x;
		logic [7:0]                          column_y;
		logic [7:0]                          column_bits;
		frgf_pkg::status_t                   status;
		logic                                glyph_done;
	} glyph_result_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we;
	logic [frgf_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [frgf_pkg::CFG_DATA_BITS-1:0]  cfg_data;

	frgf_in_if in_if ();
	frgf_out_if #(.COORD_BITS(frgf_pkg::COORD_BITS_DEF)) out_if ();

	font_rom_glyph_fetcher #(
		.COORD_BITS(frgf_pkg::COORD_BITS_DEF)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_if),
		.out(out_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow registers and decode state of the fetcher
	logic [7:0]                          reg_start_x = 8'd0;
	logic [7:0]                          reg_start_y = 8'd0;
	logic [23:0]                         reg_ascii_base = frgf_pkg::ASCII_BASE_RESET;
	logic [23:0]                         reg_hanzi_base = frgf_pkg::HANZI_BASE_RESET;
	logic [7:0]                          lead_byte = 8'd0;
	logic                                lead_held = 1'b0;
	logic [frgf_pkg::COORD_BITS_DEF-1:0] cursor_x = '0;
	logic                                glyph_wide = 1'b0;
	logic [5:0]                          reply_idx = 6'd0;
	logic                                fetch_on = 1'b0;
	logic                                eot_pending = 1'b0;

	fetch_in_t     in_byte_q[$];
	glyph_result_t out_result_q[$];
	fetch_in_t     drv_item;
	logic          drv_busy = 1'b0;
	logic          hold_next = 1'b0;

	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int items_pushed = 0;
	int items_accepted = 0;
	int results_checked = 0;
	int glyphs_drawn = 0;
	int status_seen = 0;
	int reg_settings = 1;
	int mismatches = 0;
	int quiet_cycles = 0;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] mirror_byte(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7-i] = v[i];
		end
		return r;
	endfunction

	task automatic add_result(input frgf_pkg::res_kind_t kind, input logic [7:0] spi,
		input logic cs, input logic [frgf_pkg::COORD_BITS_DEF-1:0] x, input logic [7:0] y,
		input logic [7:0] bits, input frgf_pkg::status_t st, input logic done);
		glyph_result_t r;
		r.kind = kind;
		r.spi_byte = spi;
		r.chip_select = cs;
		r.column_x = x;
		r.column_y = y;
		r.column_bits = bits;
		r.status = st;
		r.glyph_done = done;
		out_result_q.push_back(r);
	endtask

	task automatic add_spi(input logic [7:0] b);
		add_result(frgf_pkg::KIND_SPI, b, 1'b1, '0, 8'd0, 8'd0, frgf_pkg::ST_OK, 1'b0);
	endtask

	task automatic add_status(input frgf_pkg::status_t st);
		add_result(frgf_pkg::KIND_STATUS, 8'd0, 1'b0, '0, 8'd0, 8'd0, st, 1'b1);
	endtask

	task automatic advance_cursor(input logic [7:0] width, input logic eot);
		cursor_x = cursor_x + width;
		if (eot) begin
			cursor_x = reg_start_x;
		end
	endtask

	task automatic reject_code(input logic [7:0] width, input logic eot);
		advance_cursor(width, eot);
		add_status(frgf_pkg::ST_INVALID);
	endtask

	// read command, address high first, dummy and the first clock byte
	task automatic start_fetch(input logic [23:0] addr, input logic wide, input logic eot);
		fetch_on = 1'b1;
		glyph_wide = wide;
		reply_idx = 6'd0;
		eot_pending = eot;
		add_spi(frgf_pkg::SPI_FAST_READ);
		add_spi(addr[23:16]);
		add_spi(addr[15:8]);
		add_spi(addr[7:0]);
		add_spi(frgf_pkg::SPI_DUMMY);
		add_spi(frgf_pkg::SPI_CLOCK);
	endtask

	// expected results of one accepted input transaction
	task automatic fetch_step(input fetch_in_t it);
		logic [7:0]  b;
		logic [7:0]  half;
		logic [7:0]  col;
		logic [7:0]  row_y;
		logic        last;
		logic        code_ok;
		logic [23:0] addr;
		int unsigned row;
		b = it.data_byte;
		if (it.func == FUNC_REPLY) begin
			if (!fetch_on) begin
				add_status(frgf_pkg::ST_UNEXPECTED);
			end else begin
				half = glyph_wide ? 8'd16 : 8'd8;
				if (8'(reply_idx) < half) begin
					col = 8'(reply_idx);
					row_y = reg_start_y;
				end else begin
					col = 8'(reply_idx) - half;
					row_y = reg_start_y + 8'd8;
				end
				last = (8'(reply_idx) >= 8'(2 * half - 1));
				add_result(frgf_pkg::KIND_COLUMN, 8'd0, !last, cursor_x + col, row_y,
					mirror_byte(b), frgf_pkg::ST_OK, last);
				if (!last) begin
					reply_idx = reply_idx + 6'd1;
					add_spi(frgf_pkg::SPI_CLOCK);
				end else begin
					fetch_on = 1'b0;
					reply_idx = 6'd0;
					advance_cursor(half, eot_pending);
					eot_pending = 1'b0;
				end
			end
		end else if (fetch_on) begin
			// text while a glyph is still streaming is dropped
			add_status(frgf_pkg::ST_UNEXPECTED);
		end else if (lead_held) begin
			// second byte of a double-byte code
			lead_held = 1'b0;
			code_ok = 1'b1;
			row = 0;
			if (lead_byte >= frgf_pkg::GB_LEAD_MIN && lead_byte <= frgf_pkg::GB_SYM_LAST) begin
				row = 32'(lead_byte - frgf_pkg::GB_LEAD_MIN);
			end else if (lead_byte == frgf_pkg::GB_SYM_EXTRA) begin
				row = 32'(frgf_pkg::HANZI_ROW_A9);
			end else if (lead_byte >= frgf_pkg::GB_HANZI_MIN &&
					lead_byte <= frgf_pkg::GB_HANZI_MAX) begin
				row = 32'(lead_byte - frgf_pkg::GB_HANZI_MIN) + 32'(frgf_pkg::HANZI_ROW_B0);
			end else begin
				code_ok = 1'b0;
			end
			if (!code_ok || b < frgf_pkg::GB_TRAIL_MIN || b > frgf_pkg::GB_TRAIL_MAX) begin
				reject_code(8'd16, it.end_of_text);
			end else begin
				addr = 24'(32'(reg_hanzi_base) + (row * 32'(frgf_pkg::HANZI_ROW_LEN)
					+ 32'(b - frgf_pkg::GB_TRAIL_MIN)) * 32'd32);
				start_fetch(addr, 1'b1, it.end_of_text);
			end
		end else if (b >= frgf_pkg::GB_LEAD_MIN) begin
			// lead byte: held, unless the string ends on it
			if (it.end_of_text) begin
				reject_code(8'd16, 1'b1);
			end else begin
				lead_byte = b;
				lead_held = 1'b1;
			end
		end else if (b < frgf_pkg::ASCII_MIN || b > frgf_pkg::ASCII_MAX) begin
			reject_code(8'd8, it.end_of_text);
		end else begin
			addr = reg_ascii_base + 24'(b - frgf_pkg::ASCII_MIN) * 24'd16;
			start_fetch(addr, 1'b0, it.end_of_text);
		end
	endtask

	task automatic push_item(input logic f, input logic [7:0] d, input logic e);
		fetch_in_t t;
		t.func = f;
		t.data_byte = d;
		t.end_of_text = e;
		t.hold = hold_next || ($urandom_range(39) == 0);
		hold_next = 1'b0;
		in_byte_q.push_back(t);
		items_pushed++;
	endtask

	// one glyph: optional lead, code byte, replies, maybe a text byte cut in
	task automatic push_glyph(input logic pair, input logic [7:0] lead, input logic [7:0] code,
		input logic eot, input int replies, input int intrude_at);
		if (pair) begin
			push_item(FUNC_TEXT, lead, 1'b0);
		end
		push_item(FUNC_TEXT, code, eot);
		for (int i = 0; i < replies; i++) begin
			if (i == intrude_at) begin
				push_item(FUNC_TEXT, 8'($urandom_range(255)), 1'($urandom_range(1)));
			end
			push_item(FUNC_REPLY, 8'($urandom_range(255)), 1'($urandom_range(1)));
		end
	endtask

	function automatic logic [7:0] pick_ascii();
		int r;
		r = $urandom_range(7);
		if (r == 0) begin
			return frgf_pkg::ASCII_MIN;
		end else if (r == 1) begin
			return frgf_pkg::ASCII_MAX;
		end
		return 8'($urandom_range(frgf_pkg::ASCII_MAX, frgf_pkg::ASCII_MIN));
	endfunction

	function automatic logic [7:0] pick_lead();
		int r;
		r = $urandom_range(9);
		if (r == 0) begin
			return 8'(frgf_pkg::GB_LEAD_MIN
				+ $urandom_range(frgf_pkg::GB_SYM_LAST - frgf_pkg::GB_LEAD_MIN));
		end else if (r == 1) begin
			return frgf_pkg::GB_SYM_EXTRA;
		end else if (r == 2) begin
			return frgf_pkg::GB_HANZI_MIN;
		end else if (r == 3) begin
			return frgf_pkg::GB_HANZI_MAX;
		end
		return 8'($urandom_range(frgf_pkg::GB_HANZI_MAX, frgf_pkg::GB_HANZI_MIN));
	endfunction

	function automatic logic [7:0] pick_trail();
		int r;
		r = $urandom_range(7);
		if (r == 0) begin
			return frgf_pkg::GB_TRAIL_MIN;
		end else if (r == 1) begin
			return frgf_pkg::GB_TRAIL_MAX;
		end
		return 8'($urandom_range(frgf_pkg::GB_TRAIL_MAX, frgf_pkg::GB_TRAIL_MIN));
	endfunction

	// mostly complete glyphs with random pixels, the rest broken or stray input
	task automatic random_text(input int n);
		int         stop_at;
		int         pick;
		int         v;
		logic       eot;
		logic [7:0] b;
		stop_at = items_pushed + n;
		while (items_pushed < stop_at) begin
			pick = $urandom_range(99);
			eot = ($urandom_range(4) == 0);
			if (pick < 35) begin
				push_glyph(1'b0, 8'd0, pick_ascii(), eot, 16, NO_INTRUSION);
			end else if (pick < 68) begin
				push_glyph(1'b1, pick_lead(), pick_trail(), eot, 32, NO_INTRUSION);
			end else if (pick < 74) begin
				// single byte outside the printable range
				v = $urandom_range(65);
				b = (v < 32) ? 8'(v) : 8'(8'h7F + (v - 32));
				push_item(FUNC_TEXT, b, eot);
			end else if (pick < 80) begin
				// pair with an unknown lead or a trail out of range
				if ($urandom_range(1)) begin
					case ($urandom_range(2))
						0: b = 8'(8'hA4 + $urandom_range(4));
						1: b = 8'(8'hAA + $urandom_range(5));
						default: b = 8'(8'hF8 + $urandom_range(7));
					endcase
					push_glyph(1'b1, b, 8'($urandom_range(255)), eot, 0, NO_INTRUSION);
				end else begin
					v = $urandom_range(8'hA1);
					b = (v == 8'hA1) ? 8'hFF : 8'(v);
					push_glyph(1'b1, pick_lead(), b, eot, 0, NO_INTRUSION);
				end
			end else if (pick < 84) begin
				push_item(FUNC_TEXT, 8'($urandom_range(8'hFF, 8'hA1)), 1'b1);
			end else if (pick < 88) begin
				push_item(FUNC_REPLY, 8'($urandom_range(255)), 1'($urandom_range(1)));
			end else if (pick < 94) begin
				if ($urandom_range(1)) begin
					push_glyph(1'b0, 8'd0, pick_ascii(), eot, 16, $urandom_range(15));
				end else begin
					push_glyph(1'b1, pick_lead(), pick_trail(), eot, 32, $urandom_range(31));
				end
			end else if (pick < 97) begin
				// fetch cut short, later text runs into it
				push_glyph(1'b0, 8'd0, pick_ascii(), eot, $urandom_range(15, 1), NO_INTRUSION);
			end else begin
				push_item(1'($urandom_range(1)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
			end
		end
	endtask

	// wait for quiet, then feed replies to any glyph left half fetched
	task automatic settle();
		do begin
			while (in_byte_q.size() != 0 || drv_busy || out_result_q.size() != 0) begin
				@(posedge clk);
			end
			repeat (SETTLE_GAP) @(posedge clk);
			if (fetch_on) begin
				repeat ((glyph_wide ? 32 : 16) - reply_idx) begin
					push_item(FUNC_REPLY, 8'($urandom_range(255)), 1'b0);
				end
			end
		end while (fetch_on);
	endtask

	task automatic write_reg(input frgf_pkg::cfg_reg_t idx, input logic [23:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			frgf_pkg::REG_START_X: begin
				reg_start_x = v[7:0];
				cursor_x = v[frgf_pkg::COORD_BITS_DEF-1:0];
			end
			frgf_pkg::REG_START_Y: reg_start_y = v[7:0];
			frgf_pkg::REG_ASCII_BASE: reg_ascii_base = v;
			frgf_pkg::REG_HANZI_BASE: reg_hanzi_base = v;
			default: ;
		endcase
	endtask

	task automatic load_regs(input logic [7:0] sx, input logic [7:0] sy,
		input logic [23:0] ascii_base, input logic [23:0] hanzi_base);
		write_reg(frgf_pkg::REG_START_X, 24'(sx));
		write_reg(frgf_pkg::REG_START_Y, 24'(sy));
		write_reg(frgf_pkg::REG_ASCII_BASE, ascii_base);
		write_reg(frgf_pkg::REG_HANZI_BASE, hanzi_base);
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_settings++;
	endtask

	function automatic void check_field(input string what, input logic [23:0] want_v,
		input logic [23:0] got_v);
		if (got_v !== want_v) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v,
					got_v);
			end
		end
	endfunction

	// input driver, one transaction held until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid <= 1'b0;
			in_if.func <= FUNC_TEXT;
			in_if.data_byte <= 8'd0;
			in_if.end_of_text <= 1'b0;
			drv_busy = 1'b0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				fetch_step(drv_item);
				items_accepted++;
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (in_byte_q.size() != 0 && !(in_byte_q[0].hold && out_result_q.size() != 0)
					&& $urandom_range(99) >= snd_idle_pct) begin
					drv_item = in_byte_q.pop_front();
					drv_busy = 1'b1;
					in_if.valid <= 1'b1;
					in_if.func <= drv_item.func;
					in_if.data_byte <= drv_item.data_byte;
					in_if.end_of_text <= drv_item.end_of_text;
				end else begin
					in_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	glyph_result_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				if (out_result_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: result with nothing expected, expected none, actual kind %0h",
							$time, out_if.kind);
					end
				end else begin
					want = out_result_q.pop_front();
					check_field("kind", 24'(want.kind), 24'(out_if.kind));
					check_field("spi_byte", 24'(want.spi_byte), 24'(out_if.spi_byte));
					check_field("chip_select", 24'(want.chip_select), 24'(out_if.chip_select));
					check_field("column_x", 24'(want.column_x), 24'(out_if.column_x));
					check_field("column_y", 24'(want.column_y), 24'(out_if.column_y));
					check_field("column_bits", 24'(want.column_bits), 24'(out_if.column_bits));
					check_field("status", 24'(want.status), 24'(out_if.status));
					check_field("glyph_done", 24'(want.glyph_done), 24'(out_if.glyph_done));
					results_checked++;
					if (want.kind == frgf_pkg::KIND_COLUMN && want.glyph_done) begin
						glyphs_drawn++;
					end
					if (want.kind == frgf_pkg::KIND_STATUS) begin
						status_seen++;
					end
				end
			end
			out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// phases: reset defaults, extremes, zeros, random settings
	initial begin
		cfg_we = 1'b0;
		cfg_index = frgf_pkg::REG_START_X;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, reset register values, no idling
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		// lowest printable code, reply bits at the extremes, a pause on results
		push_item(FUNC_TEXT, frgf_pkg::ASCII_MIN, 1'b0);
		push_item(FUNC_REPLY, 8'h01, 1'b0);
		push_item(FUNC_REPLY, 8'h80, 1'b1);
		push_item(FUNC_REPLY, 8'h00, 1'b0);
		hold_next = 1'b1;
		push_item(FUNC_REPLY, 8'hFF, 1'b0);
		repeat (12) push_item(FUNC_REPLY, 8'($urandom_range(255)), 1'($urandom_range(1)));
		// last hanzi ends the string, with a text byte cut in mid fetch
		push_glyph(1'b1, frgf_pkg::GB_HANZI_MAX, frgf_pkg::GB_TRAIL_MAX, 1'b1, 32, 5);
		// codes outside the printable range, three of them just outside
		push_item(FUNC_TEXT, 8'h1F, 1'b0);
		push_item(FUNC_TEXT, 8'h7F, 1'b0);
		push_item(FUNC_TEXT, 8'hA0, 1'b1);
		push_item(FUNC_TEXT, 8'h00, 1'b0);
		// unknown lead, then trails just below and above the valid range
		push_glyph(1'b1, 8'hA4, frgf_pkg::GB_TRAIL_MIN, 1'b0, 0, NO_INTRUSION);
		push_glyph(1'b1, frgf_pkg::GB_LEAD_MIN, 8'hA0, 1'b0, 0, NO_INTRUSION);
		push_glyph(1'b1, frgf_pkg::GB_HANZI_MAX, 8'hFF, 1'b1, 0, NO_INTRUSION);
		// lead byte as the last byte of a string
		push_item(FUNC_TEXT, 8'hFF, 1'b1);
		// reply with no fetch in progress
		push_item(FUNC_REPLY, 8'h5A, 1'b0);
		settle();

		load_regs(8'd255, 8'd247, 24'hFFFFFF, 24'hFFFFFF);
		snd_idle_pct = 68;
		rcv_stall_pct = 0;
		random_text(95);
		settle();

		load_regs(8'd0, 8'd0, 24'h000000, 24'h000000);
		snd_idle_pct = 0;
		rcv_stall_pct = 68;
		random_text(95);
		settle();

		load_regs(8'($urandom_range(255)), 8'($urandom_range(247)),
			24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)));
		snd_idle_pct = 27;
		rcv_stall_pct = 27;
		random_text(95);
		settle();

		load_regs(8'($urandom_range(255)), 8'($urandom_range(247)), frgf_pkg::ASCII_BASE_RESET,
			24'($urandom_range(24'hFFFFFF)));
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		random_text(95);
		settle();

		if (out_result_q.size() != 0) begin
			mismatches++;
			$display("%0t: %0d results never arrived", $time, out_result_q.size());
		end
		$display("run covered %0d input transactions and %0d results over %0d register settings",
			items_accepted, results_checked, reg_settings);
		$display("glyphs drawn: %0d, status results: %0d, mismatches: %0d", glyphs_drawn,
			status_seen, mismatches);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
